@@ hw/rtl/bdpa_pkg.sv @@
// Shared types and constants for the binary delta patch applier.
// No dependencies; imported by bdpa_ram and binary_delta_patch_apply_top.
package bdpa_pkg;

  localparam int OLD_ADDR_BITS_DEFAULT = 20;

  localparam int OLD_LEN_BITS = 21;
  localparam int NEW_LEN_BITS = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int WORD_BITS = 64;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD    = 2'd0;
  localparam op_t OP_CONTROL = 2'd1;
  localparam op_t OP_DATA    = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_BYTE    = 2'd0;
  localparam status_t ST_CORRUPT = 2'd1;
  localparam status_t ST_STRAY   = 2'd2;

  localparam logic CFG_OLD_LENGTH = 1'b0;
  localparam logic CFG_NEW_LENGTH = 1'b1;

  // One result waiting for its old-store byte.
  typedef struct packed {
    logic       valid;
    logic       use_old;
    logic [7:0] data;
    logic [31:0] pos;
    logic       last;
    status_t    status;
  } stage_t;

endpackage

@@ hw/rtl/bdpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Uses bdpa_pkg for the default address width.
module bdpa_ram
  import bdpa_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int ADDR_BITS = OLD_ADDR_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/binary_delta_patch_apply_top.sv @@
// Binary delta patch applier: old-image store, control tracking and byte rebuild.
// Depends on bdpa_pkg and bdpa_ram.
//
// Load the old image with operation 0 (one byte per transaction), then send a
// control triple (operation 1) followed by its patch bytes (operation 2).
// Transactions may follow on every cycle while the result stage is free or its
// result can move on; a result passes through the result stage, loaded with the
// registered read of the old-image RAM (addressed from the running old position
// at accept time), and then the output register. Loads and accepted controls
// give no result; a bad control or a stray data byte gives one result
// with a nonzero status. The old store has no reset: read only loaded bytes.
module binary_delta_patch_apply_top
  import bdpa_pkg::*;
#(
  parameter int OLD_ADDR_BITS = OLD_ADDR_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_en,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic [OLD_ADDR_BITS-1:0] address,
  input  logic [7:0]               data_byte,
  input  logic [WORD_BITS-1:0]     add_word,
  input  logic [WORD_BITS-1:0]     copy_word,
  input  logic [WORD_BITS-1:0]     seek_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               new_byte,
  output logic [31:0]              position,
  output logic                     last,
  output logic [1:0]               status
);

  logic [OLD_LEN_BITS-1:0] old_length;
  logic [NEW_LEN_BITS-1:0] new_length;
  logic [31:0]             write_position;
  logic [WORD_BITS-1:0]    old_position;
  logic [31:0]             add_remaining;
  logic [31:0]             copy_remaining;
  logic [WORD_BITS-1:0]    pending_seek;
  logic [WORD_BITS-1:0]    pending_seek_p1;

  logic [31:0]             write_position_next;
  logic [WORD_BITS-1:0]    old_position_next;
  logic [31:0]             add_remaining_next;
  logic [31:0]             copy_remaining_next;
  logic [WORD_BITS-1:0]    pending_seek_next;
  logic [WORD_BITS-1:0]    pending_seek_p1_next;

  stage_t stage;
  stage_t stage_next;

  logic       out_free;
  logic       accept;
  logic [7:0] ram_q;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !stage.valid || out_free;
  assign accept   = in_valid && in_ready;

  bdpa_ram #(
    .WIDTH    (8),
    .ADDR_BITS(OLD_ADDR_BITS)
  ) u_old_store (
    .clk  (clk),
    .we   (accept && operation == OP_LOAD),
    .waddr(address),
    .wdata(data_byte),
    .re   (accept),
    .raddr(old_position[OLD_ADDR_BITS-1:0]),
    .rdata(ram_q)
  );

  // Control word decode
  logic [62:0]          add_mag;
  logic [62:0]          copy_mag;
  logic [62:0]          seek_mag;
  logic [WORD_BITS-1:0] seek_twos;
  logic [WORD_BITS-1:0] seek_twos_p1;
  logic [31:0]          room;
  logic                 ctrl_bad;
  logic                 use_old;
  logic [WORD_BITS-1:0] old_pos_addend;
  logic [31:0]          write_position_inc;

  assign add_mag  = add_word[62:0];
  assign copy_mag = copy_word[62:0];
  assign seek_mag = seek_word[62:0];
  assign seek_twos    = seek_word[63] ? (64'd0 - {1'b0, seek_mag}) : {1'b0, seek_mag};
  assign seek_twos_p1 = seek_word[63] ? (64'd1 - {1'b0, seek_mag}) : ({1'b0, seek_mag} + 64'd1);
  assign room = (write_position <= new_length) ? (new_length - write_position) : 32'd0;
  assign write_position_inc = write_position + 32'd1;

  always_comb begin
    ctrl_bad = 1'b0;
    if (add_remaining != 32'd0 || copy_remaining != 32'd0) begin
      ctrl_bad = 1'b1;
    end
    if ((add_word[63] && add_mag != 63'd0) || (copy_word[63] && copy_mag != 63'd0)) begin
      ctrl_bad = 1'b1;
    end
    if (add_mag[62:32] != 31'd0 || add_mag[31:0] > room) begin
      ctrl_bad = 1'b1;
    end else if (copy_mag[62:32] != 31'd0 || copy_mag[31:0] > (room - add_mag[31:0])) begin
      ctrl_bad = 1'b1;
    end
  end

  // Old byte is used only inside both the loaded image and the store
  assign use_old = (old_position[WORD_BITS-1:OLD_LEN_BITS] == '0)
                && (old_position[OLD_LEN_BITS-1:0] < old_length)
                && (old_position[WORD_BITS-1:OLD_ADDR_BITS] == '0);

  always_comb begin
    write_position_next  = write_position;
    add_remaining_next   = add_remaining;
    copy_remaining_next  = copy_remaining;
    pending_seek_next    = pending_seek;
    pending_seek_p1_next = pending_seek_p1;
    old_pos_addend       = '0;
    stage_next           = stage;
    if (out_free) begin
      stage_next.valid = 1'b0;
    end
    if (accept) begin
      stage_next.valid   = 1'b0;
      stage_next.use_old = 1'b0;
      stage_next.data    = 8'd0;
      stage_next.pos     = write_position;
      stage_next.last    = 1'b0;
      stage_next.status  = ST_BYTE;
      unique case (operation)
        OP_LOAD: begin
        end
        OP_CONTROL: begin
          if (ctrl_bad) begin
            stage_next.valid  = 1'b1;
            stage_next.status = ST_CORRUPT;
          end else begin
            add_remaining_next  = add_mag[31:0];
            copy_remaining_next = copy_mag[31:0];
            if (add_mag == 63'd0 && copy_mag == 63'd0) begin
              old_pos_addend    = seek_twos;
              pending_seek_next = '0;
            end else begin
              pending_seek_next    = seek_twos;
              pending_seek_p1_next = seek_twos_p1;
            end
          end
        end
        OP_DATA: begin
          if (add_remaining != 32'd0) begin
            add_remaining_next  = add_remaining - 32'd1;
            write_position_next = write_position_inc;
            stage_next.valid    = 1'b1;
            stage_next.use_old  = use_old;
            stage_next.data     = data_byte;
            stage_next.last     = (write_position_inc == new_length);
            if (add_remaining == 32'd1 && copy_remaining == 32'd0) begin
              old_pos_addend    = pending_seek_p1;
              pending_seek_next = '0;
            end else begin
              old_pos_addend = 64'd1;
            end
          end else if (copy_remaining != 32'd0) begin
            copy_remaining_next = copy_remaining - 32'd1;
            write_position_next = write_position_inc;
            stage_next.valid    = 1'b1;
            stage_next.data     = data_byte;
            stage_next.last     = (write_position_inc == new_length);
            if (copy_remaining == 32'd1) begin
              old_pos_addend    = pending_seek;
              pending_seek_next = '0;
            end
          end else begin
            stage_next.valid  = 1'b1;
            stage_next.status = ST_STRAY;
          end
        end
        default: begin
        end
      endcase
    end
    old_position_next = old_position + old_pos_addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      old_length      <= '0;
      new_length      <= '0;
      write_position  <= '0;
      old_position    <= '0;
      add_remaining   <= '0;
      copy_remaining  <= '0;
      pending_seek    <= '0;
      pending_seek_p1 <= '0;
      stage.valid     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          CFG_OLD_LENGTH: old_length <= cfg_data[OLD_LEN_BITS-1:0];
          CFG_NEW_LENGTH: new_length <= cfg_data[NEW_LEN_BITS-1:0];
          default: begin
          end
        endcase
      end
      write_position  <= write_position_next;
      old_position    <= old_position_next;
      add_remaining   <= add_remaining_next;
      copy_remaining  <= copy_remaining_next;
      pending_seek    <= pending_seek_next;
      pending_seek_p1 <= pending_seek_p1_next;
      stage           <= stage_next;
      if (out_free) begin
        out_valid <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage.valid) begin
      new_byte <= stage.use_old ? (stage.data + ram_q) : stage.data;
      position <= stage.pos;
      last     <= stage.last;
      status   <= stage.status;
    end
  end

  // A stuck result stage must hold off new transactions (RAM data would be lost)
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    stage.valid && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stage is blocked");

  // Error results carry no byte and never mark the end of the image
  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_BYTE |-> new_byte == 8'd0 && !last)
    else $error("error result with byte or last set");

  // A control arriving during a pending run is rejected
  a_busy_control: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_CONTROL && (add_remaining != 32'd0 || copy_remaining != 32'd0)
    |=> stage.valid && stage.status == ST_CORRUPT
        && add_remaining == $past(add_remaining) && copy_remaining == $past(copy_remaining))
    else $error("control accepted during a pending run");

  // Each run byte advances the write position by exactly one
  a_write_advance: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_DATA && (add_remaining != 32'd0 || copy_remaining != 32'd0)
    |=> write_position == $past(write_position) + 32'd1)
    else $error("write position did not advance on a run byte");

endmodule
